### hw/rtl/word_hash_engine_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the word hash engine
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WORD_HASH_ENGINE_CORE_ASSERT_SVH
`define WORD_HASH_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define WHE_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define WHE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/whe_pkg.sv
// ----------------------------------------------------------------------------
// whe_pkg
// Constants shared by the word hash engine and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package whe_pkg;

	localparam int unsigned HASH_W          = 32;
	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned MODE_W          = 3;
	localparam int unsigned LENGTH_BITS_DEF = 16;

	localparam logic [HASH_W-1:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [HASH_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

	localparam logic [MODE_W-1:0] MODE_ZERO  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FIRST = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LEN   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SUM   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_AVG   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ROR   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_ROL   = 3'd6;
	localparam logic [MODE_W-1:0] MODE_CRC   = 3'd7;

	typedef logic [HASH_W-1:0] hash_t;

endpackage

`default_nettype wire

### hw/rtl/word_hash_engine_core.sv
// ----------------------------------------------------------------------------
// word_hash_engine_core
// Byte-stream word hasher: one 32-bit hash per word, mode chosen by register.
// ----------------------------------------------------------------------------
// Bytes arrive one per transaction on s_axis, tlast marking the final byte of
// a word; that byte yields one hash on m_axis. Each byte is first accepted,
// updating first-byte, sum, rotate and length state, and then runs one pass
// of the shift-xor step per bit for the CRC. After the final byte the result
// register is loaded, in mode 4 only after the same step sequencer has run
// one restoring division bit per cycle for the 32 quotient bits. A result
// waiting in the output register does not block the next word's bytes, but
// a later result waits until that one is taken. hash_mode resets to CRC-32
// and may be written only while the engine is idle.
`timescale 1ns / 1ps
`default_nettype none

module word_hash_engine_core import whe_pkg::*; #(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output      logic              cfg_ready,
	input  wire logic [MODE_W-1:0] cfg_data,       // [2:0] hash_mode
	input  wire logic              s_axis_tvalid,
	output      logic              s_axis_tready,
	input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic              s_axis_tlast,   // last_byte
	output      logic              m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output      logic [HASH_W-1:0] m_axis_tdata    // [31:0] word_digest
);

	localparam int unsigned STEP_W = $clog2(HASH_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CRC  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [STEP_W-1:0]      CRC_LAST  = STEP_W'(BYTE_W - 1);
	localparam logic [STEP_W-1:0]      DIV_LAST  = STEP_W'(HASH_W - 1);
	localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

	logic [1:0]             state_q;
	logic [STEP_W-1:0]      step_q;
	logic [MODE_W-1:0]      mode_q;
	hash_t                  sum_q;
	hash_t                  ror_q;
	hash_t                  rol_q;
	hash_t                  crc_q;
	logic [LENGTH_BITS-1:0] count_q;
	logic [BYTE_W-1:0]      first_q;
	logic                   last_q;
	logic [LENGTH_BITS:0]   rem_q;
	logic                   out_valid_q;
	hash_t                  out_data_q;

	logic                 in_acc;
	logic                 out_free;
	logic                 out_load;
	hash_t                byte_sext;
	hash_t                first_sext;
	logic [LENGTH_BITS:0] rem_shift;
	logic [LENGTH_BITS:0] divisor;
	logic                 rem_ge;
	hash_t                hash_sel;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = (state_q == ST_DONE) && out_free;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign byte_sext  = {{(HASH_W - BYTE_W){s_axis_tdata[BYTE_W-1]}}, s_axis_tdata};
	assign first_sext = {{(HASH_W - BYTE_W){first_q[BYTE_W-1]}}, first_q};

	// restoring division step, quotient shifts into sum_q
	assign rem_shift = {rem_q[LENGTH_BITS-1:0], sum_q[HASH_W-1]};
	assign divisor   = {1'b0, count_q};
	assign rem_ge    = (rem_shift >= divisor);

	always_comb begin
		unique case (mode_q)
			MODE_ZERO:  hash_sel = '0;
			MODE_FIRST: hash_sel = first_sext;
			MODE_LEN:   hash_sel = HASH_W'(count_q);
			MODE_SUM:   hash_sel = sum_q;
			MODE_AVG:   hash_sel = sum_q;
			MODE_ROR:   hash_sel = ror_q;
			MODE_ROL:   hash_sel = rol_q;
			MODE_CRC:   hash_sel = crc_q ^ ALL_ONES;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			mode_q      <= MODE_CRC;
			sum_q       <= '0;
			ror_q       <= '0;
			rol_q       <= '0;
			crc_q       <= ALL_ONES;
			count_q     <= '0;
			first_q     <= '0;
			last_q      <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (count_q == '0) begin
							first_q <= s_axis_tdata;
						end
						sum_q   <= sum_q + byte_sext;
						ror_q   <= {ror_q[0], ror_q[HASH_W-1:1]} ^ byte_sext;
						rol_q   <= {rol_q[HASH_W-2:0], rol_q[HASH_W-1]} ^ byte_sext;
						crc_q   <= crc_q ^ HASH_W'(s_axis_tdata);
						if (count_q != COUNT_MAX) begin
							count_q <= count_q + 1'b1;
						end
						last_q  <= s_axis_tlast;
						step_q  <= '0;
						state_q <= ST_CRC;
					end
				end
				ST_CRC: begin
					crc_q <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
					if (step_q == CRC_LAST) begin
						step_q <= '0;
						rem_q  <= '0;
						if (!last_q) begin
							state_q <= ST_IDLE;
						end else if (mode_q == MODE_AVG) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DIV: begin
					rem_q  <= rem_ge ? (rem_shift - divisor) : rem_shift;
					sum_q  <= {sum_q[HASH_W-2:0], rem_ge};
					step_q <= step_q + 1'b1;
					if (step_q == DIV_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						sum_q   <= '0;
						ror_q   <= '0;
						rol_q   <= '0;
						crc_q   <= ALL_ONES;
						count_q <= '0;
						first_q <= '0;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= hash_sel;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/whe_checker.sv
// ----------------------------------------------------------------------------
// whe_checker
// Port-level checks for the word hash engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "word_hash_engine_core_assert.svh"

module whe_checker import whe_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_axis_tvalid,
	input wire logic              s_axis_tready,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [HASH_W-1:0] m_axis_tdata
);

	logic s_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	`WHE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`WHE_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	// a byte keeps the engine busy through its CRC steps
	`WHE_ASSERT_NEXT(a_busy_after_byte, s_acc, !s_axis_tready)
	// no result can appear the cycle after a byte is taken
	`WHE_ASSERT_NEXT(a_no_early_result, s_acc && !m_axis_tvalid, !m_axis_tvalid)

endmodule

bind word_hash_engine_core whe_checker u_whe_checker (.*);

`default_nettype wire
